### sv/mf5_pkg.sv
// Types, constants and the five-input median function shared by the median filter.
package mf5_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TAPS     = 5;
   localparam int WINDOW   = 7;
   localparam int CNT_W    = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CNT_W-1:0]           count_type;

   localparam count_type SEEN_NONE = 2'd0;
   localparam count_type SEEN_ONE  = 2'd1;
   localparam count_type SEEN_RUN  = 2'd2;

   typedef struct packed {
      logic [WINDOW-1:0][SAMPLE_W-1:0] tap;
      count_type                       count;
      logic                            last;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   function automatic sample_type median5(input logic [TAPS-1:0][SAMPLE_W-1:0] w);
      sample_type res;
      logic [2:0] rank;
      res = '0;
      for (int i = 0; i < TAPS; i++) begin
         rank = '0;
         for (int j = 0; j < TAPS; j++) begin
            if (j != i) begin
               if ($signed(w[j]) < $signed(w[i]) || (w[j] == w[i] && j < i)) begin
                  rank = rank + 3'd1;
               end
            end
         end
         if (rank == 3'(TAPS / 2)) begin
            res = w[i];
         end
      end
      return res;
   endfunction

endpackage

### sv/median_filter_5tap.sv
// Five-tap median filter over a stream of signed 16-bit samples, edges mirrored.
// Each item is one sample with its end-of-signal flag on req_tlast. Results lag
// the input by two samples: the first two samples of a signal give nothing, each
// later one gives one median, and the final sample gives one, two or three results
// (signal length one, two, or more), the last marked on rsp_tlast. The front
// stage takes one item per cycle while the job queue has room; the back stage
// runs one median window per cycle while its output register is empty or being
// taken, so ordinary samples flow at one per cycle when nothing stalls, and a final
// sample holds the back stage for up to three windows. The queue is written at
// the accepting edge and the output register loads from the queue head later.
module median_filter_5tap #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mf5_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample
   input  logic                          req_tlast,   // end_of_signal
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mf5_pkg::SAMPLE_W-1:0]  rsp_tdata,   // [15:0] median_value
   output logic                          rsp_tlast    // last_result
);

   mf5_pkg::push_type push;
   mf5_pkg::head_type head;
   logic              full;
   logic              pop;
   logic              accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   mf5_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .sample        (req_tdata),
      .end_of_signal (req_tlast),
      .push          (push)
   );

   mf5_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (full),
      .head  (head)
   );

   mf5_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sv/mf5_front.sv
// Front stage: accepts samples, keeps the window history and builds median jobs.
module mf5_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [mf5_pkg::SAMPLE_W-1:0]   sample,
   input  logic                           end_of_signal,
   output mf5_pkg::push_type              push
);

   mf5_pkg::sample_type hist_ff [4];
   mf5_pkg::sample_type hist_in [4];
   mf5_pkg::count_type  seen_ff;
   mf5_pkg::count_type  seen_in;
   mf5_pkg::sample_type x;

   assign x = mf5_pkg::sample_type'(sample);

   always_comb begin
      hist_in      = hist_ff;
      seen_in      = seen_ff;
      push.valid   = 1'b0;
      push.job.tap = '0;
      push.job.count = 2'd1;
      push.job.last  = end_of_signal;
      if (!end_of_signal) begin
         case (seen_ff)
            mf5_pkg::SEEN_NONE: begin
               hist_in[0] = x;
               seen_in    = mf5_pkg::SEEN_ONE;
            end
            mf5_pkg::SEEN_ONE: begin
               hist_in[0] = x;
               hist_in[1] = hist_ff[0];
               hist_in[2] = hist_ff[0];
               hist_in[3] = x;
               seen_in    = mf5_pkg::SEEN_RUN;
            end
            default: begin
               push.valid     = 1'b1;
               push.job.tap[0] = hist_ff[3];
               push.job.tap[1] = hist_ff[2];
               push.job.tap[2] = hist_ff[1];
               push.job.tap[3] = hist_ff[0];
               push.job.tap[4] = x;
               push.job.tap[5] = x;
               push.job.tap[6] = x;
               hist_in[3] = hist_ff[2];
               hist_in[2] = hist_ff[1];
               hist_in[1] = hist_ff[0];
               hist_in[0] = x;
               seen_in    = mf5_pkg::SEEN_RUN;
            end
         endcase
      end else begin
         push.valid = 1'b1;
         case (seen_ff)
            mf5_pkg::SEEN_NONE: begin
               for (int i = 0; i < mf5_pkg::WINDOW; i++) begin
                  push.job.tap[i] = x;
               end
               push.job.count = 2'd1;
            end
            mf5_pkg::SEEN_ONE: begin
               push.job.tap[0] = x;
               push.job.tap[1] = hist_ff[0];
               push.job.tap[2] = hist_ff[0];
               push.job.tap[3] = x;
               push.job.tap[4] = x;
               push.job.tap[5] = hist_ff[0];
               push.job.tap[6] = hist_ff[0];
               push.job.count  = 2'd2;
            end
            default: begin
               push.job.tap[0] = hist_ff[3];
               push.job.tap[1] = hist_ff[2];
               push.job.tap[2] = hist_ff[1];
               push.job.tap[3] = hist_ff[0];
               push.job.tap[4] = x;
               push.job.tap[5] = x;
               push.job.tap[6] = hist_ff[0];
               push.job.count  = 2'd3;
            end
         endcase
         for (int i = 0; i < 4; i++) begin
            hist_in[i] = '0;
         end
         seen_in = mf5_pkg::SEEN_NONE;
      end
      if (!accept) begin
         push.valid = 1'b0;
         hist_in    = hist_ff;
         seen_in    = seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= mf5_pkg::SEEN_NONE;
         for (int i = 0; i < 4; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         seen_ff <= seen_in;
         hist_ff <= hist_in;
      end
   end

endmodule

### sv/mf5_queue.sv
// Job queue between the front and back stages.
module mf5_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  mf5_pkg::push_type  push,
   input  logic               pop,
   output logic               full,
   output mf5_pkg::head_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mf5_pkg::job_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("job offered to full queue");

endmodule

### sv/mf5_back.sv
// Back stage: walks each job's windows through the median unit into the output register.
module mf5_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mf5_pkg::head_type             head,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mf5_pkg::SAMPLE_W-1:0]  rsp_tdata,
   output logic                          rsp_tlast
);

   logic                                      out_valid_ff;
   mf5_pkg::sample_type                       out_data_ff, out_data_in;
   logic                                      out_last_ff, out_last_in;
   mf5_pkg::count_type                        k_ff, k_in;
   logic                                      load, final_win;
   logic [mf5_pkg::TAPS-1:0][mf5_pkg::SAMPLE_W-1:0] win;

   assign load      = head.valid && (!out_valid_ff || rsp_tready);
   assign final_win = (k_ff == head.job.count - mf5_pkg::count_type'(1));
   assign pop       = load && final_win;

   always_comb begin
      case (k_ff)
         2'd0:    win = head.job.tap[4:0];
         2'd1:    win = head.job.tap[5:1];
         2'd2:    win = head.job.tap[6:2];
         default: win = head.job.tap[4:0];
      endcase
      out_data_in = mf5_pkg::median5(win);
      out_last_in = head.job.last && final_win;
      k_in        = k_ff;
      if (load) begin
         k_in = final_win ? '0 : k_ff + mf5_pkg::count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         k_ff <= k_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   a_k_in_job: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> (k_ff < head.job.count))
      else $error("window index beyond job");

   a_k_rewind: assert property (@(posedge clock) disable iff (reset)
      pop |=> (k_ff == '0))
      else $error("window index not rewound after job");

   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      (load && out_last_in) |-> pop)
      else $error("last result without job retire");

endmodule

### test/median_filter_5tap_check.sv
// Checker for the five-tap median filter: predicts medians from accepted samples and compares.
`timescale 1ns / 1ps
module median_filter_5tap_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tlast,   // end_of_signal
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] median_value
   input  logic        rsp_tlast,   // last_result
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      mf5_pkg::sample_type value;
      logic                last;
   } median_type;

   median_type          medians_due[$];
   median_type          want;
   mf5_pkg::sample_type hist [4];
   mf5_pkg::count_type  seen;

   function automatic mf5_pkg::sample_type mid_of_five(input mf5_pkg::sample_type a,
                                                      input mf5_pkg::sample_type b,
                                                      input mf5_pkg::sample_type c,
                                                      input mf5_pkg::sample_type d,
                                                      input mf5_pkg::sample_type e);
      mf5_pkg::sample_type v [5];
      mf5_pkg::sample_type t;
      v[0] = a;
      v[1] = b;
      v[2] = c;
      v[3] = d;
      v[4] = e;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4 - i; j++) begin
            if (v[j] > v[j+1]) begin
               t      = v[j];
               v[j]   = v[j+1];
               v[j+1] = t;
            end
         end
      end
      return v[2];
   endfunction

   task automatic add_median(input mf5_pkg::sample_type v, input logic last);
      median_type r;
      r.value = v;
      r.last  = last;
      medians_due.push_back(r);
   endtask

   task automatic clear_history();
      for (int i = 0; i < 4; i++) begin
         hist[i] = '0;
      end
      seen = mf5_pkg::SEEN_NONE;
   endtask

   task automatic take_sample(input mf5_pkg::sample_type x, input logic fin);
      mf5_pkg::sample_type s0;
      s0 = hist[0];
      if (!fin) begin
         if (seen == mf5_pkg::SEEN_NONE) begin
            hist[0] = x;
            seen    = mf5_pkg::SEEN_ONE;
         end else if (seen == mf5_pkg::SEEN_ONE) begin
            // mirror the start: newest first s1, s0, s0, s1
            hist[0] = x;
            hist[1] = s0;
            hist[2] = s0;
            hist[3] = x;
            seen    = mf5_pkg::SEEN_RUN;
         end else begin
            add_median(mid_of_five(hist[3], hist[2], hist[1], hist[0], x), 1'b0);
            hist[3] = hist[2];
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = x;
            seen    = mf5_pkg::SEEN_RUN;
         end
      end else begin
         if (seen == mf5_pkg::SEEN_NONE) begin
            add_median(x, 1'b1);
         end else if (seen == mf5_pkg::SEEN_ONE) begin
            add_median(mid_of_five(x, s0, s0, x, x), 1'b0);
            add_median(mid_of_five(s0, s0, x, x, s0), 1'b1);
         end else begin
            // flush with the end mirrored as s[N-1], s[N-2]
            add_median(mid_of_five(hist[3], hist[2], hist[1], hist[0], x), 1'b0);
            add_median(mid_of_five(hist[2], hist[1], hist[0], x, x), 1'b0);
            add_median(mid_of_five(hist[1], hist[0], x, x, hist[0]), 1'b1);
         end
         clear_history();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_history();
         medians_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (medians_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected median %0d last %0b at %0t",
                           $signed(rsp_tdata), rsp_tlast, $realtime);
               end
            end else begin
               want = medians_due.pop_front();
               if (want.value !== rsp_tdata || want.last !== rsp_tlast) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("median mismatch at %0t: expected %0d last %0b, got %0d last %0b",
                              $realtime, want.value, want.last, $signed(rsp_tdata), rsp_tlast);
                  end
               end
            end
         end
      end
      outstanding = medians_due.size();
   end

endmodule

### test/median_filter_5tap_test.sv
// Top of the median filter testbench: clock, reset, sample stimulus and the verdict.
`timescale 1ns / 1ps
module median_filter_5tap_test;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] sample
   logic        req_tlast;   // end_of_signal
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] median_value
   logic        rsp_tlast;   // last_result
   int          mismatches;
   int          outstanding;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          sent      = 0;

   median_filter_5tap dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   median_filter_5tap_check median_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #200000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         4, 5: return 16'($urandom_range(8)) + 16'hfffc;   // -4..4, plenty of ties
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   task automatic send_sample(input logic [15:0] s, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = s;
      req_tlast  = fin;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
      sent++;
   endtask

   task automatic send_signal(input int room);
      int len;
      case ($urandom_range(9))
         0: len = 1;
         1: len = 2;
         2: len = 3;
         3: len = $urandom_range(80, 40);
         default: len = $urandom_range(16, 4);
      endcase
      if (len > room) begin
         len = room;
      end
      for (int i = 0; i < len; i++) begin
         send_sample(pick_sample(), i == len - 1);
      end
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input int idle, input int stall, input int budget);
      int start;
      start     = sent;
      idle_pct  = idle;
      stall_pct = stall;
      while (sent - start < budget) begin
         send_signal(budget - (sent - start));
      end
      drain();
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // one-sample signals pass through
      send_sample(16'h7fff, 1'b1);
      send_sample(16'h8000, 1'b1);
      // two-sample signal
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7fff, 1'b1);
      // three-sample signal
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0001, 1'b1);
      // longer run through the extremes
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hffff, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'h7fff, 1'b0);
      send_sample(16'h8000, 1'b1);
      // all equal
      send_sample(16'h0005, 1'b0);
      send_sample(16'h0005, 1'b0);
      send_sample(16'h0005, 1'b0);
      send_sample(16'h0005, 1'b1);
      drain();

      run_phase(0, 0, 100);
      run_phase(71, 0, 100);
      run_phase(0, 71, 100);
      run_phase(29, 29, 100);

      repeat (20) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
